/* hw/rtl/wmc_pkg.sv */
`default_nettype none
package wmc_pkg;

  localparam int unsigned PosMax = 100;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_SET_POS = 3'd1,
    CMD_TEMP    = 3'd2,
    CMD_ALARM   = 3'd3,
    CMD_AUTO    = 3'd4,
    CMD_MANUAL  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_INIT   = 2'd0,
    MODE_AUTO   = 2'd1,
    MODE_MANUAL = 2'd2
  } op_mode_t;

  typedef enum logic {
    CFG_THRESHOLD = 1'b0,
    CFG_INTERVAL  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    cmd_t        cmd;
    logic        remote_event;
    logic        use_button;
    logic        pos_ok;
    logic [6:0]  pos;
    logic [11:0] temp;
    logic        alarm_value;
    logic [6:0]  pot;
    logic [31:0] time_ms;
  } item_t;

  typedef struct packed {
    logic        servo_write;
    logic [6:0]  servo_percent;
    logic        send_pot_notice;
    logic        send_mode_notice;
    logic        send_mode_ack;
    op_mode_t    op_mode;
    logic        alarm_active;
    logic [11:0] temp_out;
    logic        temp_valid;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/wmc_front.sv */
`default_nettype none
module wmc_front (
  input  wire logic [2:0]          in_mode,
  input  wire logic signed [15:0]  in_cmd_value,
  input  wire logic signed [11:0]  in_temp_value,
  input  wire logic                in_alarm_value,
  input  wire logic                in_button_pressed,
  input  wire logic [6:0]          in_pot_percent,
  input  wire logic [31:0]         in_time_ms,
  output wmc_pkg::item_t           item
);
  import wmc_pkg::*;

  cmd_t cmd;
  logic remote_event;

  always_comb begin
    case (in_mode)
      CMD_SET_POS, CMD_TEMP, CMD_ALARM, CMD_AUTO, CMD_MANUAL: cmd = cmd_t'(in_mode);
      default: cmd = CMD_NONE;
    endcase
  end

  assign remote_event = (cmd == CMD_SET_POS) || (cmd == CMD_TEMP) ||
                        (cmd == CMD_AUTO) || (cmd == CMD_MANUAL);

  always_comb begin
    item.cmd          = cmd;
    item.remote_event = remote_event;
    item.use_button   = in_button_pressed && !remote_event;
    item.pos_ok       = (in_cmd_value >= 16'sd0) && (in_cmd_value <= 16'(PosMax));
    item.pos          = in_cmd_value[6:0];
    item.temp         = in_temp_value;
    item.alarm_value  = in_alarm_value;
    item.pot          = (in_pot_percent > 7'(PosMax)) ? 7'(PosMax) : in_pot_percent;
    item.time_ms      = in_time_ms;
  end

endmodule
`default_nettype wire

/* hw/rtl/wmc_queue.sv */
`default_nettype none
module wmc_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wmc_pkg::item_t      push_item,
  input  wire logic           pop,
  output wmc_pkg::item_t      pop_item,
  output wmc_pkg::q_stat_t    stat
);
  import wmc_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t             mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count missed a push");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == CNT_W'(DEPTH)) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers out of step");

endmodule
`default_nettype wire

/* hw/rtl/wmc_back.sv */
`default_nettype none
module wmc_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_valid,
  input  wire logic          cfg_index,
  input  wire logic [15:0]   cfg_data,
  input  wmc_pkg::q_stat_t   q_stat,
  input  wmc_pkg::item_t     item,
  output logic               q_pop,
  input  wire logic          out_pop,
  output logic               out_empty,
  output wmc_pkg::result_t   res
);
  import wmc_pkg::*;

  logic [6:0]  threshold_r;
  logic [15:0] interval_r;
  op_mode_t    mode_r, mode_nxt;
  logic [6:0]  target_r, target_nxt;
  logic [6:0]  last_pot_r, last_pot_nxt;
  logic [31:0] last_time_r, last_time_nxt;
  logic        alarm_r, alarm_nxt;
  logic [11:0] temp_r, temp_nxt;
  logic        temp_known_r, temp_known_nxt;
  logic        out_valid_r;
  result_t     res_r, res_nxt;

  logic        step;
  logic [6:0]  pot_diff;
  logic [31:0] elapsed;
  logic        moved, due;

  assign step      = q_pop;
  assign q_pop     = !q_stat.empty && (!out_valid_r || out_pop);
  assign out_empty = !out_valid_r;
  assign res       = res_r;

  assign pot_diff = (item.pot >= last_pot_r) ? item.pot - last_pot_r : last_pot_r - item.pot;
  assign moved    = pot_diff >= threshold_r;
  assign elapsed  = item.time_ms - last_time_r;
  assign due      = elapsed >= {16'd0, interval_r};

  always_comb begin
    alarm_nxt      = alarm_r;
    temp_nxt       = temp_r;
    temp_known_nxt = temp_known_r;
    mode_nxt       = mode_r;
    target_nxt     = target_r;
    last_pot_nxt   = last_pot_r;
    last_time_nxt  = last_time_r;
    res_nxt        = '0;

    if (item.cmd == CMD_TEMP) begin
      temp_nxt       = item.temp;
      temp_known_nxt = 1'b1;
    end else if (item.cmd == CMD_ALARM) begin
      alarm_nxt = item.alarm_value;
    end

    case (mode_r)
      MODE_AUTO: begin
        if (item.use_button && !alarm_nxt) begin
          res_nxt.send_mode_notice = 1'b1;
          mode_nxt = MODE_MANUAL;
        end else if (item.cmd == CMD_MANUAL && !alarm_nxt) begin
          res_nxt.send_mode_ack = 1'b1;
          mode_nxt = MODE_MANUAL;
        end else if (item.cmd == CMD_SET_POS && item.pos_ok) begin
          target_nxt          = item.pos;
          res_nxt.servo_write = 1'b1;
        end
        if (mode_nxt == MODE_MANUAL) begin
          target_nxt              = item.pot;
          last_pot_nxt            = item.pot;
          res_nxt.servo_write     = 1'b1;
          res_nxt.send_pot_notice = 1'b1;
        end
      end
      MODE_MANUAL: begin
        if (item.use_button && !alarm_nxt) begin
          res_nxt.send_mode_notice = 1'b1;
          mode_nxt = MODE_AUTO;
        end else if (item.cmd == CMD_AUTO && !alarm_nxt) begin
          res_nxt.send_mode_ack = 1'b1;
          mode_nxt = MODE_AUTO;
        end else if (!alarm_nxt) begin
          if (item.cmd == CMD_SET_POS && item.pos_ok) begin
            target_nxt          = item.pos;
            last_pot_nxt        = item.pot;
            last_time_nxt       = item.time_ms;
            res_nxt.servo_write = 1'b1;
          end else if (moved) begin
            target_nxt              = item.pot;
            last_pot_nxt            = item.pot;
            res_nxt.send_pot_notice = 1'b1;
            if (due) begin
              last_time_nxt       = item.time_ms;
              res_nxt.servo_write = 1'b1;
            end
          end
        end
      end
      MODE_INIT: begin
        if (!item.remote_event) begin
          mode_nxt = MODE_AUTO;
        end
      end
      default: begin
        mode_nxt = mode_r;
      end
    endcase

    res_nxt.servo_percent = target_nxt;
    res_nxt.op_mode       = mode_nxt;
    res_nxt.alarm_active  = alarm_nxt;
    res_nxt.temp_out      = temp_nxt;
    res_nxt.temp_valid    = temp_known_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r  <= 7'd5;
      interval_r   <= 16'd100;
      mode_r       <= MODE_INIT;
      target_r     <= '0;
      last_pot_r   <= '0;
      last_time_r  <= '0;
      alarm_r      <= 1'b0;
      temp_r       <= '0;
      temp_known_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_idx_t'(cfg_index))
          CFG_THRESHOLD: threshold_r <= cfg_data[6:0];
          CFG_INTERVAL:  interval_r  <= cfg_data;
          default:       threshold_r <= threshold_r;
        endcase
      end
      if (step) begin
        mode_r       <= mode_nxt;
        target_r     <= target_nxt;
        last_pot_r   <= last_pot_nxt;
        last_time_r  <= last_time_nxt;
        alarm_r      <= alarm_nxt;
        temp_r       <= temp_nxt;
        temp_known_r <= temp_known_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_pop) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end

  a_one_notice: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.send_mode_notice && res_r.send_mode_ack))
    else $error("mode notice and ack in one word");

  a_pot_manual: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.send_pot_notice) |-> (res_r.op_mode == MODE_MANUAL))
    else $error("pot notice outside manual mode");

  a_no_init_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.servo_write) |-> (res_r.op_mode != MODE_INIT))
    else $error("servo write in init");

  a_result_state: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> (res_r.op_mode == mode_r && res_r.servo_percent == target_r))
    else $error("result word out of step with state");

endmodule
`default_nettype wire

/* hw/rtl/window_mode_controller.sv */
`default_nettype none
// Window mode controller. Each input word is one controller tick (remote
// command, button, potentiometer, time) and yields exactly one result word
// with the servo command, notices and the mode, alarm and temperature after
// the tick. One tick is taken every cycle while in_full is low: a small
// front decodes the tick into a queue of QUEUE_DEPTH words, and the back
// applies one queued tick per cycle, while the result register is free,
// to the mode state and loads the result register, which drives the out_
// ports; a held result stalls the back and the queue fills behind it.
// Write registers (index 0 change threshold, index 1 servo interval in ms)
// only while idle.
module window_mode_controller #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire logic [2:0]         in_mode,
  input  wire logic signed [15:0] in_cmd_value,
  input  wire logic signed [11:0] in_temp_value,
  input  wire logic               in_alarm_value,
  input  wire logic               in_button_pressed,
  input  wire logic [6:0]         in_pot_percent,
  input  wire logic [31:0]        in_time_ms,
  output logic                    empty,
  input  wire logic               pop,
  output logic                    out_servo_write,
  output logic [6:0]              out_servo_percent,
  output logic                    out_send_pot_notice,
  output logic                    out_send_mode_notice,
  output logic                    out_send_mode_ack,
  output logic [1:0]              out_op_mode,
  output logic                    out_alarm_active,
  output logic signed [11:0]      out_temp_out,
  output logic                    out_temp_valid,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [15:0]        cfg_data
);
  import wmc_pkg::*;

  item_t   front_item;
  item_t   back_item;
  q_stat_t q_stat;
  logic    q_pop;
  result_t res;

  assign cfg_ready = 1'b1;
  assign in_full   = q_stat.full;

  wmc_front u_front (
    .in_mode           (in_mode),
    .in_cmd_value      (in_cmd_value),
    .in_temp_value     (in_temp_value),
    .in_alarm_value    (in_alarm_value),
    .in_button_pressed (in_button_pressed),
    .in_pot_percent    (in_pot_percent),
    .in_time_ms        (in_time_ms),
    .item              (front_item)
  );

  wmc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_item (front_item),
    .pop       (q_pop),
    .pop_item  (back_item),
    .stat      (q_stat)
  );

  wmc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .item      (back_item),
    .q_pop     (q_pop),
    .out_pop   (pop),
    .out_empty (empty),
    .res       (res)
  );

  assign out_servo_write      = res.servo_write;
  assign out_servo_percent    = res.servo_percent;
  assign out_send_pot_notice  = res.send_pot_notice;
  assign out_send_mode_notice = res.send_mode_notice;
  assign out_send_mode_ack    = res.send_mode_ack;
  assign out_op_mode          = res.op_mode;
  assign out_alarm_active     = res.alarm_active;
  assign out_temp_out         = res.temp_out;
  assign out_temp_valid       = res.temp_valid;

endmodule
`default_nettype wire

/* dv/window_mode_controller_tb.sv */
`default_nettype none
module window_mode_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wmc_pkg::*;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] cmd_value;
    logic [11:0] temp_value;
    logic        alarm_value;
    logic        button_pressed;
    logic [6:0]  pot_percent;
    logic [31:0] time_ms;
  } tick_t;

  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned RandomTicksPerPhase = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_push = 1'b0;
  logic        in_full;
  logic [2:0]  in_mode = '0;
  logic [15:0] in_cmd_value = '0;
  logic [11:0] in_temp_value = '0;
  logic        in_alarm_value = 1'b0;
  logic        in_button_pressed = 1'b0;
  logic [6:0]  in_pot_percent = '0;
  logic [31:0] in_time_ms = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        out_servo_write;
  logic [6:0]  out_servo_percent;
  logic        out_send_pot_notice;
  logic        out_send_mode_notice;
  logic        out_send_mode_ack;
  logic [1:0]  out_op_mode;
  logic        out_alarm_active;
  logic [11:0] out_temp_out;
  logic        out_temp_valid;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  window_mode_controller u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_mode             (in_mode),
    .in_cmd_value        (in_cmd_value),
    .in_temp_value       (in_temp_value),
    .in_alarm_value      (in_alarm_value),
    .in_button_pressed   (in_button_pressed),
    .in_pot_percent      (in_pot_percent),
    .in_time_ms          (in_time_ms),
    .empty               (empty),
    .pop                 (pop),
    .out_servo_write     (out_servo_write),
    .out_servo_percent   (out_servo_percent),
    .out_send_pot_notice (out_send_pot_notice),
    .out_send_mode_notice(out_send_mode_notice),
    .out_send_mode_ack   (out_send_mode_ack),
    .out_op_mode         (out_op_mode),
    .out_alarm_active    (out_alarm_active),
    .out_temp_out        (out_temp_out),
    .out_temp_valid      (out_temp_valid),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #4 clk = ~clk;

  // window controller state as the block should hold it
  op_mode_t    win_mode = MODE_INIT;
  logic [6:0]  win_target = '0;
  logic [6:0]  win_last_pot = '0;
  logic [31:0] win_last_wr = '0;
  logic        win_alarm = 1'b0;
  logic [11:0] win_temp = '0;
  logic        win_temp_known = 1'b0;
  logic [6:0]  win_thr = 7'd5;
  logic [15:0] win_interval = 16'd100;

  tick_t   pending_ticks[$];
  result_t expected_results[$];
  tick_t   drive_tick;
  tick_t   seen_tick;
  result_t want;

  int unsigned ticks_queued = 0;
  int unsigned ticks_accepted = 0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_gap = 0;
  int unsigned pop_hold = 0;
  int unsigned pop_draw;
  logic        took_in = 1'b0;
  logic        took_out = 1'b0;
  logic        calm = 1'b0;
  int          gen_pot = 0;
  logic [31:0] gen_time = 32'd5000;

  function automatic result_t next_window_state(tick_t t);
    result_t    r;
    logic       remote;
    logic       pos_ok;
    logic       use_btn;
    logic [6:0] pot;
    logic [6:0] d;
    int         cv;
    cv = $signed(t.cmd_value);
    remote = (t.mode == CMD_SET_POS) || (t.mode == CMD_TEMP) ||
             (t.mode == CMD_AUTO) || (t.mode == CMD_MANUAL);
    pos_ok = (cv >= 0) && (cv <= int'(PosMax));
    use_btn = t.button_pressed && !remote;
    pot = (t.pot_percent > 7'(PosMax)) ? 7'(PosMax) : t.pot_percent;
    r = '0;
    if (t.mode == CMD_TEMP) begin
      win_temp = t.temp_value;
      win_temp_known = 1'b1;
    end else if (t.mode == CMD_ALARM) begin
      win_alarm = t.alarm_value;
    end
    case (win_mode)
      MODE_AUTO: begin
        if (use_btn && !win_alarm) begin
          r.send_mode_notice = 1'b1;
          win_mode = MODE_MANUAL;
        end else if (t.mode == CMD_MANUAL && !win_alarm) begin
          win_mode = MODE_MANUAL;
          r.send_mode_ack = 1'b1;
        end else if (t.mode == CMD_SET_POS && pos_ok) begin
          win_target = 7'(cv);
          r.servo_write = 1'b1;
        end
        if (win_mode == MODE_MANUAL) begin
          win_target = pot;
          win_last_pot = pot;
          r.servo_write = 1'b1;
          r.send_pot_notice = 1'b1;
        end
      end
      MODE_MANUAL: begin
        if (use_btn && !win_alarm) begin
          r.send_mode_notice = 1'b1;
          win_mode = MODE_AUTO;
        end else if (t.mode == CMD_AUTO && !win_alarm) begin
          win_mode = MODE_AUTO;
          r.send_mode_ack = 1'b1;
        end else if (!win_alarm) begin
          if (t.mode == CMD_SET_POS && pos_ok) begin
            win_target = 7'(cv);
            r.servo_write = 1'b1;
            win_last_wr = t.time_ms;
            win_last_pot = pot;
          end else begin
            d = (pot >= win_last_pot) ? pot - win_last_pot : win_last_pot - pot;
            if (d >= win_thr) begin
              win_target = pot;
              win_last_pot = pot;
              if (t.time_ms - win_last_wr >= {16'd0, win_interval}) begin
                r.servo_write = 1'b1;
                win_last_wr = t.time_ms;
              end
              r.send_pot_notice = 1'b1;
            end
          end
        end
      end
      default: begin
        if (!remote) win_mode = MODE_AUTO;
      end
    endcase
    r.servo_percent = win_target;
    r.op_mode = win_mode;
    r.alarm_active = win_alarm;
    r.temp_out = win_temp;
    r.temp_valid = win_temp_known;
    return r;
  endfunction

  function automatic tick_t make_tick(logic [2:0] m, int cv, int tv, bit av, bit bt,
                                      int pt, logic [31:0] tm);
    tick_t t;
    t.mode = m;
    t.cmd_value = 16'(cv);
    t.temp_value = 12'(tv);
    t.alarm_value = av;
    t.button_pressed = bt;
    t.pot_percent = 7'(pt);
    t.time_ms = tm;
    return t;
  endfunction

  function automatic tick_t random_tick();
    tick_t       t;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) t.mode = CMD_NONE;
    else if (r < 60) t.mode = CMD_SET_POS;
    else if (r < 68) t.mode = CMD_TEMP;
    else if (r < 76) t.mode = CMD_ALARM;
    else if (r < 84) t.mode = CMD_AUTO;
    else if (r < 92) t.mode = CMD_MANUAL;
    else t.mode = 3'($urandom_range(6, 7));
    if ($urandom_range(0, 99) < 70) t.cmd_value = 16'($urandom_range(0, 100));
    else t.cmd_value = 16'($urandom);
    t.temp_value = 12'($urandom);
    t.alarm_value = ($urandom_range(0, 99) < 35);
    t.button_pressed = ($urandom_range(0, 99) < 12);
    r = $urandom_range(0, 99);
    if (r < 60) gen_pot = gen_pot + $urandom_range(0, 30) - 15;
    else if (r < 90) gen_pot = $urandom_range(0, 100);
    else gen_pot = $urandom_range(101, 127);
    if (gen_pot < 0) gen_pot = 0;
    if (gen_pot > 127) gen_pot = 127;
    t.pot_percent = 7'(gen_pot);
    r = $urandom_range(0, 99);
    if (r < 80) gen_time = gen_time + $urandom_range(0, 150);
    else if (r < 95) gen_time = gen_time + $urandom_range(150, 3000);
    else gen_time = $urandom;
    t.time_ms = gen_time;
    return t;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  task automatic flag_mismatch(string msg);
    if (fail_count < 40) $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] exp_val);
    if (got !== exp_val) begin
      flag_mismatch($sformatf("%s got %0h want %0h", name, got, exp_val));
    end
  endtask

  task automatic queue_tick(tick_t t);
    pending_ticks.push_back(t);
    ticks_queued++;
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (ticks_accepted != ticks_queued || expected_results.size() != 0) @(negedge clk);
  endtask

  // input side: advance to the next word once the current one is taken
  always @(negedge clk) begin
    if (in_push && !took_in) begin
    end else if (send_gap != 0) begin
      in_push <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_ticks.size() != 0) begin
      drive_tick = pending_ticks.pop_front();
      in_mode <= drive_tick.mode;
      in_cmd_value <= drive_tick.cmd_value;
      in_temp_value <= drive_tick.temp_value;
      in_alarm_value <= drive_tick.alarm_value;
      in_button_pressed <= drive_tick.button_pressed;
      in_pot_percent <= drive_tick.pot_percent;
      in_time_ms <= drive_tick.time_ms;
      in_push <= 1'b1;
      send_gap <= pick_gap();
    end else begin
      in_push <= 1'b0;
    end
  end

  // result side: stall for a random stretch after some words
  always @(negedge clk) begin
    pop_draw = took_out ? pick_gap() : 0;
    if (pop_hold != 0) begin
      pop <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else if (pop_draw != 0) begin
      pop <= 1'b0;
      pop_hold <= pop_draw - 1;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      took_in <= 1'b0;
      took_out <= 1'b0;
    end else begin
      took_in <= in_push && !in_full;
      took_out <= pop && !empty;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_THRESHOLD) win_thr = cfg_data[6:0];
        else win_interval = cfg_data;
      end
      if (in_push && !in_full) begin
        seen_tick.mode = in_mode;
        seen_tick.cmd_value = in_cmd_value;
        seen_tick.temp_value = in_temp_value;
        seen_tick.alarm_value = in_alarm_value;
        seen_tick.button_pressed = in_button_pressed;
        seen_tick.pot_percent = in_pot_percent;
        seen_tick.time_ms = in_time_ms;
        expected_results.push_back(next_window_state(seen_tick));
        ticks_accepted++;
      end
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          flag_mismatch("result word with nothing expected");
        end else begin
          want = expected_results.pop_front();
          compare_field("servo_write", out_servo_write, want.servo_write);
          compare_field("servo_percent", out_servo_percent, want.servo_percent);
          compare_field("send_pot_notice", out_send_pot_notice, want.send_pot_notice);
          compare_field("send_mode_notice", out_send_mode_notice, want.send_mode_notice);
          compare_field("send_mode_ack", out_send_mode_ack, want.send_mode_ack);
          compare_field("op_mode", out_op_mode, want.op_mode);
          compare_field("alarm_active", out_alarm_active, want.alarm_active);
          compare_field("temp_out", $unsigned(out_temp_out), want.temp_out);
          compare_field("temp_valid", out_temp_valid, want.temp_valid);
        end
      end
      if ((in_push && !in_full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
          $display("timeout with %0d results outstanding", expected_results.size());
          $display("[window_mode_controller] ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned thr_set[6];
    int unsigned intv_set[6];
    thr_set = '{5, 0, 100, 1, 0, 5};
    intv_set = '{100, 0, 65535, 1, 0, 100};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    queue_tick(make_tick(CMD_TEMP, 0, -2048, 0, 0, 0, 1000));
    queue_tick(make_tick(CMD_MANUAL, 0, 0, 0, 1, 10, 1020));
    queue_tick(make_tick(CMD_NONE, 0, 0, 0, 1, 10, 1030));
    queue_tick(make_tick(CMD_SET_POS, 0, 0, 0, 0, 10, 1040));
    queue_tick(make_tick(CMD_SET_POS, 100, 0, 0, 0, 10, 1050));
    queue_tick(make_tick(CMD_SET_POS, 101, 0, 0, 0, 10, 1060));
    queue_tick(make_tick(CMD_SET_POS, -32768, 0, 0, 0, 10, 1070));
    queue_tick(make_tick(CMD_SET_POS, 32767, 0, 0, 0, 10, 1080));
    queue_tick(make_tick(CMD_AUTO, 0, 0, 0, 0, 10, 1085));
    queue_tick(make_tick(CMD_TEMP, 0, 2047, 1, 1, 10, 1090));
    queue_tick(make_tick(CMD_NONE, 0, 0, 0, 1, 127, 1100));
    queue_tick(make_tick(CMD_MANUAL, 0, 0, 0, 0, 98, 1150));
    queue_tick(make_tick(CMD_NONE, 0, 0, 0, 0, 60, 1200));
    queue_tick(make_tick(CMD_NONE, 0, 0, 0, 0, 25, 1250));
    queue_tick(make_tick(CMD_SET_POS, 70, 0, 0, 0, 25, 1260));
    queue_tick(make_tick(CMD_SET_POS, 200, 0, 0, 0, 0, 1270));
    queue_tick(make_tick(CMD_ALARM, 0, 0, 1, 0, 90, 1280));
    queue_tick(make_tick(CMD_NONE, 0, 0, 0, 1, 50, 1290));
    queue_tick(make_tick(CMD_SET_POS, 30, 0, 0, 0, 50, 1300));
    queue_tick(make_tick(CMD_ALARM, 0, 0, 0, 0, 50, 1310));
    queue_tick(make_tick(3'd7, 0, 0, 0, 1, 50, 1320));
    queue_tick(make_tick(CMD_ALARM, 0, 0, 1, 0, 50, 1330));
    queue_tick(make_tick(CMD_SET_POS, 40, 0, 0, 0, 50, 1340));
    queue_tick(make_tick(CMD_MANUAL, 0, 0, 1, 0, 50, 1350));
    queue_tick(make_tick(CMD_ALARM, 0, 0, 0, 0, 50, 1360));
    queue_tick(make_tick(CMD_MANUAL, 0, 0, 0, 0, 50, 32'hFFFF_FFF0));
    queue_tick(make_tick(3'd6, 0, 0, 0, 0, 0, 32'h0000_0010));

    for (int p = 0; p < 6; p++) begin
      if (p != 0) begin
        if (p == 4) begin
          thr_set[p] = $urandom_range(0, 100);
          intv_set[p] = $urandom_range(0, 65535);
        end
        write_reg(CFG_THRESHOLD, {9'($urandom), 7'(thr_set[p])});
        write_reg(CFG_INTERVAL, 16'(intv_set[p]));
      end
      calm = (p == 2);
      for (int i = 0; i < RandomTicksPerPhase; i++) queue_tick(random_tick());
      wait_drained();
    end

    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("[window_mode_controller] OK");
    end else begin
      $display("[window_mode_controller] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
